>>> sv/owbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_pkg
// Types, register indexes and helpers shared by the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int TIMER_WIDTH   = 10;
   localparam int CSR_WIDTH     = 10;
   localparam int CSR_IDX_WIDTH = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_WIDTH-1:0] REG_RESET_LOW     = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_PRESENCE_WAIT = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_RESET_RECOVER = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_SHORT_LOW     = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_SLOT          = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_READ_LOW      = 3'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_READ_RECOVER  = 3'd6;

   // Command opcodes.
   localparam logic [1:0] OP_RESET = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   typedef struct packed {
      logic                  cmd_valid;
      logic [1:0]            opcode;
      logic [7:0]            write_data;
      logic                  line_level;
   } owbm_req_type;

   typedef struct packed {
      logic                  drive_low;
      logic                  busy_res;
      logic                  done_res;
      logic [7:0]            read_byte;
      logic                  presence_absent;
   } owbm_rsp_type;

   typedef struct packed {
      logic [CSR_WIDTH-1:0]  reset_low_time;
      logic [CSR_WIDTH-1:0]  presence_wait_time;
      logic [CSR_WIDTH-1:0]  reset_recover_time;
      logic [CSR_WIDTH-1:0]  short_low_time;
      logic [CSR_WIDTH-1:0]  slot_time;
      logic [CSR_WIDTH-1:0]  read_low_time;
      logic [CSR_WIDTH-1:0]  read_recover_time;
   } owbm_cfg_type;

   // Timer load for a phase of the given length; a zero length counts as one tick.
   function automatic logic [TIMER_WIDTH-1:0] load_of(input logic [CSR_WIDTH-1:0] len);
      logic [CSR_WIDTH-1:0] dec;
      dec = (len == '0) ? '0 : len - CSR_WIDTH'(1);
      return TIMER_WIDTH'(dec);
   endfunction

endpackage
`default_nettype wire

>>> sv/owbm_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_csr
// Timing registers of the bus master, written through a plain write port.
// ----------------------------------------------------------------------------
module owbm_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [owbm_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [owbm_pkg::CSR_WIDTH-1:0]   csr_wdata,
   output owbm_pkg::owbm_cfg_type                cfg
);
   import owbm_pkg::*;

   owbm_cfg_type cfg_ff;
   owbm_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_RESET_LOW:     cfg_in.reset_low_time     = csr_wdata;
            REG_PRESENCE_WAIT: cfg_in.presence_wait_time = csr_wdata;
            REG_RESET_RECOVER: cfg_in.reset_recover_time = csr_wdata;
            REG_SHORT_LOW:     cfg_in.short_low_time     = csr_wdata;
            REG_SLOT:          cfg_in.slot_time          = csr_wdata;
            REG_READ_LOW:      cfg_in.read_low_time      = csr_wdata;
            REG_READ_RECOVER:  cfg_in.read_recover_time  = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_time     <= CSR_WIDTH'(480);
         cfg_ff.presence_wait_time <= CSR_WIDTH'(80);
         cfg_ff.reset_recover_time <= CSR_WIDTH'(400);
         cfg_ff.short_low_time     <= CSR_WIDTH'(1);
         cfg_ff.slot_time          <= CSR_WIDTH'(60);
         cfg_ff.read_low_time      <= CSR_WIDTH'(2);
         cfg_ff.read_recover_time  <= CSR_WIDTH'(60);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

>>> sv/owbm_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_step
// Bus phase sequencer: advances the bus state by one tick per step and
// forms the result of that tick from the new state.
// ----------------------------------------------------------------------------
module owbm_step (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step_en,
   input  wire owbm_pkg::owbm_req_type item,
   input  wire owbm_pkg::owbm_cfg_type cfg,
   output owbm_pkg::owbm_rsp_type      result
);
   import owbm_pkg::*;

   localparam logic [2:0] PH_IDLE        = 3'd0;
   localparam logic [2:0] PH_RST_LOW     = 3'd1;
   localparam logic [2:0] PH_RST_WAIT    = 3'd2;
   localparam logic [2:0] PH_RST_RECOVER = 3'd3;
   localparam logic [2:0] PH_WR_LOW      = 3'd4;
   localparam logic [2:0] PH_WR_REST     = 3'd5;
   localparam logic [2:0] PH_RD_LOW      = 3'd6;
   localparam logic [2:0] PH_RD_RECOVER  = 3'd7;

   logic [2:0]             phase_ff,    phase_in;
   logic [TIMER_WIDTH-1:0] timer_ff,    timer_in;
   logic [2:0]             bit_idx_ff,  bit_idx_in;
   logic [7:0]             shift_ff,    shift_in;
   logic                   presence_ff, presence_in;
   logic [7:0]             last_rd_ff,  last_rd_in;
   logic                   done;

   always_comb begin
      phase_in    = phase_ff;
      timer_in    = timer_ff;
      bit_idx_in  = bit_idx_ff;
      shift_in    = shift_ff;
      presence_in = presence_ff;
      last_rd_in  = last_rd_ff;
      done        = 1'b0;
      if (phase_ff == PH_IDLE) begin
         if (item.cmd_valid) begin
            case (item.opcode)
               OP_RESET: begin
                  bit_idx_in = '0;
                  phase_in   = PH_RST_LOW;
                  timer_in   = load_of(cfg.reset_low_time);
               end
               OP_WRITE: begin
                  bit_idx_in = '0;
                  shift_in   = item.write_data;
                  phase_in   = PH_WR_LOW;
                  timer_in   = load_of(item.write_data[0] ? cfg.short_low_time
                                                          : cfg.slot_time);
               end
               OP_READ: begin
                  bit_idx_in = '0;
                  shift_in   = '0;
                  phase_in   = PH_RD_LOW;
                  timer_in   = load_of(cfg.read_low_time);
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end else if (timer_ff != '0) begin
         timer_in = timer_ff - TIMER_WIDTH'(1);
      end else begin
         case (phase_ff)
            PH_RST_LOW: begin
               phase_in = PH_RST_WAIT;
               timer_in = load_of(cfg.presence_wait_time);
            end
            PH_RST_WAIT: begin
               presence_in = item.line_level;
               phase_in    = PH_RST_RECOVER;
               timer_in    = load_of(cfg.reset_recover_time);
            end
            PH_RST_RECOVER: begin
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
            PH_WR_LOW: begin
               // The release time mirrors the low time so every slot has equal length.
               phase_in = PH_WR_REST;
               timer_in = load_of(shift_ff[0] ? cfg.slot_time : cfg.short_low_time);
            end
            PH_WR_REST: begin
               if (bit_idx_ff == 3'(BITS_PER_BYTE - 1)) begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end else begin
                  bit_idx_in = bit_idx_ff + 3'd1;
                  shift_in   = {1'b0, shift_ff[7:1]};
                  phase_in   = PH_WR_LOW;
                  timer_in   = load_of(shift_ff[1] ? cfg.short_low_time : cfg.slot_time);
               end
            end
            PH_RD_LOW: begin
               shift_in = {item.line_level, shift_ff[7:1]};
               phase_in = PH_RD_RECOVER;
               timer_in = load_of(cfg.read_recover_time);
            end
            PH_RD_RECOVER: begin
               if (bit_idx_ff == 3'(BITS_PER_BYTE - 1)) begin
                  last_rd_in = shift_ff;
                  phase_in   = PH_IDLE;
                  done       = 1'b1;
               end else begin
                  bit_idx_in = bit_idx_ff + 3'd1;
                  phase_in   = PH_RD_LOW;
                  timer_in   = load_of(cfg.read_low_time);
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         timer_ff    <= '0;
         bit_idx_ff  <= '0;
         shift_ff    <= '0;
         presence_ff <= 1'b1;
         last_rd_ff  <= '0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         timer_ff    <= timer_in;
         bit_idx_ff  <= bit_idx_in;
         shift_ff    <= shift_in;
         presence_ff <= presence_in;
         last_rd_ff  <= last_rd_in;
      end
   end

   assign result.drive_low       = (phase_in == PH_RST_LOW) || (phase_in == PH_WR_LOW) ||
                                   (phase_in == PH_RD_LOW);
   assign result.busy_res        = (phase_in != PH_IDLE);
   assign result.done_res        = done;
   assign result.read_byte       = last_rd_in;
   assign result.presence_absent = presence_in;

   // Without a tick nothing in the sequencer may move.
   assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(phase_ff) && $stable(timer_ff) && $stable(shift_ff))
      else $error("sequencer state changed without a tick");

   // While the timer runs the phase holds.
   assert property (@(posedge clock) disable iff (reset)
      step_en && (phase_ff != PH_IDLE) && (timer_ff != '0) |=> phase_ff == $past(phase_ff))
      else $error("phase left before its timer expired");

   // An idle tick without a command keeps the block idle.
   assert property (@(posedge clock) disable iff (reset)
      step_en && (phase_ff == PH_IDLE) && !item.cmd_valid |=> phase_ff == PH_IDLE)
      else $error("block left idle without a command");

   // A completing tick always returns to idle.
   assert property (@(posedge clock) disable iff (reset)
      step_en && done |=> phase_ff == PH_IDLE)
      else $error("command completed but block is not idle");

endmodule
`default_nettype wire

>>> sv/one_wire_bus_master.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire bus master stepped once per microsecond tick: bus reset with
// presence detect, byte write and byte read.
//
//   Channel  Ports                          Direction  Moves
//   request  req_valid/req_ready/req_data   in         one tick item
//   response rsp_valid/rsp_ready/rsp_data   out        one result per tick
//   csr      csr_we/csr_index/csr_wdata     in         timing register write
//
// Each tick item is registered on input, advanced through the phase
// sequencer and registered as a result; one transfer per cycle is sustained
// while the response is not stalled. Synchronous reset returns the bus idle
// with the timing registers at their defaults. A stalled response holds the
// sequencer and back-pressures the request side through the input register.
// ----------------------------------------------------------------------------
module one_wire_bus_master (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_ready,
   input  wire owbm_pkg::owbm_req_type             req_data,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   output owbm_pkg::owbm_rsp_type                  rsp_data,
   input  wire logic                               csr_we,
   input  wire logic [owbm_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [owbm_pkg::CSR_WIDTH-1:0]     csr_wdata
);
   import owbm_pkg::*;

   logic         in_valid_ff;
   owbm_req_type in_data_ff;
   logic         rsp_valid_ff;
   owbm_rsp_type rsp_data_ff;
   owbm_rsp_type step_result;
   owbm_cfg_type cfg;
   logic         out_free;
   logic         step_en;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step_en   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   owbm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   owbm_step u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_data_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (step_en) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
